>>> rtl/klrp_pkg.sv
package klrp_pkg;

    // Characters the header parser and the escape decoder look for.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;

    localparam int PREFIX_W   = 11;
    localparam logic [PREFIX_W-1:0] PREFIX_MAX = 11'd2047;
    localparam int NUM_W      = 64;

    // Priority and facility reported when the prefix is zero.
    localparam logic [2:0] PRI_DEFAULT = 3'd6;
    localparam logic [7:0] FAC_DEFAULT = 8'd8;

    // Result tdata: text_byte, priority_res, facility, sequence_res, timestamp.
    localparam int FIELDS_W = 8 + 3 + 8 + NUM_W + NUM_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

    // Per-byte result queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Everything one input byte produces: up to four text bytes, then
    // optionally one end-of-message mark, tagged with the header values.
    typedef struct packed {
        logic [3:0][7:0]      bytes;
        logic [2:0]           nbytes;
        logic                 close;
        logic [PREFIX_W-1:0]  prefix;
        logic [NUM_W-1:0]     seq;
        logic [NUM_W-1:0]     ts;
    } klrp_entry_t;

endpackage

>>> rtl/klrp_front.sv
module klrp_front
    import klrp_pkg::*;
#(
    parameter int MAX_RECORD = 8192
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // record_end
    output logic        push_valid,
    input  logic        push_ready,
    output klrp_entry_t push_data
);

    localparam int BC_W = $clog2(MAX_RECORD);

    localparam logic [2:0] PH_PREFIX = 3'd0;
    localparam logic [2:0] PH_SEQ    = 3'd1;
    localparam logic [2:0] PH_TS     = 3'd2;
    localparam logic [2:0] PH_REST   = 3'd3;
    localparam logic [2:0] PH_TEXT   = 3'd4;
    localparam logic [2:0] PH_SKIP   = 3'd5;

    logic [2:0]          phase_reg, phase_next;
    logic [PREFIX_W-1:0] prefix_reg, prefix_next;
    logic [NUM_W-1:0]    seq_reg, seq_next;
    logic [NUM_W-1:0]    ts_reg, ts_next;
    logic [7:0]          digit_reg, digit_next;
    logic [1:0]          held_reg, held_next;
    logic                open_reg, open_next;
    logic [BC_W-1:0]     count_reg, count_next;
    logic                started_reg, started_next;
    logic                stopped_reg, stopped_next;
    logic                seen_reg, seen_next;

    logic [3:0][7:0]     out_bytes;
    logic [2:0]          out_cnt;
    logic                out_close;
    logic                accept;
    logic [7:0]          b;
    logic [14:0]         prefix_ext;
    logic [14:0]         prefix_mul;
    logic                cont1, cont2, cont3, brk;
    logic [7:0]          decoded;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61) begin
            v = c - 8'h57;
        end else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    // acc * 10 + d, saturating at all ones.
    function automatic logic [NUM_W-1:0] sat_dec(input logic [NUM_W-1:0] acc,
                                                 input logic [3:0] d);
        logic [NUM_W+3:0] wide;
        wide = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{NUM_W{1'b0}}, d};
        if (|wide[NUM_W+3:NUM_W]) begin
            return {NUM_W{1'b1}};
        end
        return wide[NUM_W-1:0];
    endfunction

    assign s_tready   = push_ready;
    assign accept     = s_tvalid && push_ready;
    assign b          = s_tdata;
    assign prefix_ext = {4'd0, prefix_reg};
    assign prefix_mul = (prefix_ext << 3) + (prefix_ext << 1) + {11'd0, b[3:0]};

    assign cont1   = (held_reg == 2'd1) && (b == CH_X);
    assign cont2   = (held_reg == 2'd2) && is_hex(b);
    assign cont3   = (held_reg == 2'd3) && is_hex(b);
    assign brk     = (b == CH_LF) || (b == CH_NUL);
    assign decoded = {hex_val(digit_reg), hex_val(b)};

    always_comb begin
        phase_next   = phase_reg;
        prefix_next  = prefix_reg;
        seq_next     = seq_reg;
        ts_next      = ts_reg;
        digit_next   = digit_reg;
        held_next    = held_reg;
        open_next    = open_reg;
        count_next   = count_reg;
        started_next = started_reg;
        stopped_next = stopped_reg;
        seen_next    = seen_reg;
        out_bytes    = '0;
        out_cnt      = 3'd0;
        out_close    = 1'b0;

        if (count_reg < BC_W'(MAX_RECORD - 1)) begin
            count_next = count_reg + 1'b1;
            if (phase_reg < PH_TEXT) begin
                if (b == CH_NUL) begin
                    phase_next = PH_SKIP;
                end else if (b == CH_SEMI) begin
                    if (seen_reg) begin
                        phase_next = PH_TEXT;
                    end
                end else begin
                    seen_next = 1'b1;
                    if (b == CH_COMMA) begin
                        if (phase_reg < PH_REST && started_reg) begin
                            phase_next   = phase_reg + 3'd1;
                            started_next = 1'b0;
                            stopped_next = 1'b0;
                        end
                    end else if (phase_reg < PH_REST) begin
                        started_next = 1'b1;
                        if (b >= 8'h30 && b <= 8'h39 && !stopped_reg) begin
                            case (phase_reg)
                                PH_PREFIX: begin
                                    prefix_next = (prefix_mul > 15'(PREFIX_MAX)) ?
                                                  PREFIX_MAX : prefix_mul[PREFIX_W-1:0];
                                end
                                PH_SEQ: begin
                                    seq_next = sat_dec(seq_reg, b[3:0]);
                                end
                                default: begin
                                    ts_next = sat_dec(ts_reg, b[3:0]);
                                end
                            endcase
                        end else begin
                            stopped_next = 1'b1;
                        end
                    end
                end
            end else if (phase_reg == PH_TEXT) begin
                // A broken escape first goes out literally.
                if (brk || (held_reg != 2'd0 && !cont1 && !cont2 && !cont3)) begin
                    if (held_reg >= 2'd1) begin
                        out_bytes[out_cnt[1:0]] = CH_BSLASH;
                        out_cnt = out_cnt + 3'd1;
                    end
                    if (held_reg >= 2'd2) begin
                        out_bytes[out_cnt[1:0]] = CH_X;
                        out_cnt = out_cnt + 3'd1;
                    end
                    if (held_reg == 2'd3) begin
                        out_bytes[out_cnt[1:0]] = digit_reg;
                        out_cnt = out_cnt + 3'd1;
                    end
                    if (held_reg != 2'd0) begin
                        open_next = 1'b1;
                    end
                    held_next = 2'd0;
                end
                if (brk) begin
                    if (open_next) begin
                        out_close = 1'b1;
                        open_next = 1'b0;
                    end
                    phase_next = PH_SKIP;
                end else if (cont1) begin
                    held_next = 2'd2;
                end else if (cont2) begin
                    digit_next = b;
                    held_next  = 2'd3;
                end else if (cont3) begin
                    held_next = 2'd0;
                    if (decoded == CH_NUL || decoded == CH_LF) begin
                        if (open_next) begin
                            out_close = 1'b1;
                            open_next = 1'b0;
                        end
                        if (decoded == CH_NUL) begin
                            phase_next = PH_SKIP;
                        end
                    end else begin
                        out_bytes[out_cnt[1:0]] = decoded;
                        out_cnt   = out_cnt + 3'd1;
                        open_next = 1'b1;
                    end
                end else if (b == CH_BSLASH) begin
                    held_next = 2'd1;
                end else begin
                    out_bytes[out_cnt[1:0]] = b;
                    out_cnt   = out_cnt + 3'd1;
                    open_next = 1'b1;
                end
            end
        end

        if (s_tlast) begin
            if (phase_next == PH_TEXT) begin
                if (held_next >= 2'd1) begin
                    out_bytes[out_cnt[1:0]] = CH_BSLASH;
                    out_cnt = out_cnt + 3'd1;
                end
                if (held_next >= 2'd2) begin
                    out_bytes[out_cnt[1:0]] = CH_X;
                    out_cnt = out_cnt + 3'd1;
                end
                if (held_next == 2'd3) begin
                    out_bytes[out_cnt[1:0]] = digit_next;
                    out_cnt = out_cnt + 3'd1;
                end
                if (open_next || held_next != 2'd0) begin
                    out_close = 1'b1;
                end
            end
            phase_next   = PH_PREFIX;
            prefix_next  = '0;
            seq_next     = '0;
            ts_next      = '0;
            held_next    = 2'd0;
            open_next    = 1'b0;
            count_next   = '0;
            started_next = 1'b0;
            stopped_next = 1'b0;
            seen_next    = 1'b0;
        end
    end

    // Header values do not change while text is being decoded, so the
    // current accumulators are the ones every result of this byte carries.
    assign push_valid       = s_tvalid && (out_cnt != 3'd0 || out_close);
    assign push_data.bytes  = out_bytes;
    assign push_data.nbytes = out_cnt;
    assign push_data.close  = out_close;
    assign push_data.prefix = prefix_reg;
    assign push_data.seq    = seq_reg;
    assign push_data.ts     = ts_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_PREFIX;
            prefix_reg  <= '0;
            seq_reg     <= '0;
            ts_reg      <= '0;
            held_reg    <= 2'd0;
            open_reg    <= 1'b0;
            count_reg   <= '0;
            started_reg <= 1'b0;
            stopped_reg <= 1'b0;
            seen_reg    <= 1'b0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            prefix_reg  <= prefix_next;
            seq_reg     <= seq_next;
            ts_reg      <= ts_next;
            held_reg    <= held_next;
            open_reg    <= open_next;
            count_reg   <= count_next;
            started_reg <= started_next;
            stopped_reg <= stopped_next;
            seen_reg    <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            digit_reg <= digit_next;
        end
    end

endmodule

>>> rtl/klrp_queue.sv
module klrp_queue
    import klrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  klrp_entry_t push_data,
    output logic        pop_valid,
    input  logic        pop_ready,
    output klrp_entry_t pop_data
);

    klrp_entry_t       mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/klrp_back.sv
module klrp_back
    import klrp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  klrp_entry_t        pop_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    logic [2:0]         idx_reg, idx_next;
    logic               valid_reg;
    logic [TDATA_W-1:0] data_reg;
    logic               user_reg, last_reg;

    logic               load;
    logic [2:0]         total;
    logic               is_mark;
    logic               is_final;
    logic [7:0]         text_c;
    logic [2:0]         pri_c;
    logic [7:0]         fac_c;

    assign load     = pop_valid && (!valid_reg || m_tready);
    assign total    = pop_data.nbytes + {2'd0, pop_data.close};
    assign is_mark  = (idx_reg == pop_data.nbytes);
    assign is_final = (idx_reg == total - 3'd1);
    assign text_c   = is_mark ? 8'd0 : pop_data.bytes[idx_reg[1:0]];
    assign pri_c    = (pop_data.prefix != '0) ? pop_data.prefix[2:0] : PRI_DEFAULT;
    assign fac_c    = (pop_data.prefix != '0) ? pop_data.prefix[10:3] : FAC_DEFAULT;

    assign pop_ready = load && is_final;
    assign idx_next  = is_final ? 3'd0 : idx_reg + 3'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= idx_next;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {{(TDATA_W - FIELDS_W){1'b0}}, pop_data.ts, pop_data.seq,
                         fac_c, pri_c, text_c};
            user_reg <= is_mark;
            last_reg <= is_final;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

>>> rtl/kernel_log_record_parser.sv
// Kernel log record parser.
//
// The input stream carries one raw record byte per transaction in s_tdata,
// with s_tlast on the final byte of each record. The front parses the
// comma-separated header up to ';' and decodes backslash-x hex escapes in
// the message text; the back sends one result per transaction on the
// output stream. m_tuser is 0 for a message text byte and 1 for the mark
// that ends one message. m_tlast flags the final result caused by one
// input byte. Every result carries priority, facility, sequence number and
// timestamp from the record's header.
//
// A byte's results enter the queue when it is taken, then the back's
// output register. A byte gives 0 to 5 results and the back sends each
// as its own transaction; bytes giving one result or none flow at one
// per cycle while the queue has room. A four-entry queue between front
// and back absorbs bursts; s_tready drops only when it is full. When
// m_tready is low, the output holds its transaction and the queue fills.
// Reset clears the header state, the queue and the output valid.
module kernel_log_record_parser
    import klrp_pkg::*;
#(
    parameter int MAX_RECORD = 8192
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // data_byte
    input  logic               s_tlast,   // record_end
    output logic               m_tvalid,
    input  logic               m_tready,
    // text_byte, priority_res, facility, sequence_res, timestamp, zero fill
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tuser,   // kind
    output logic               m_tlast    // last
);

    logic        push_valid, push_ready;
    klrp_entry_t push_data;
    logic        pop_valid, pop_ready;
    klrp_entry_t pop_data;

    klrp_front #(
        .MAX_RECORD (MAX_RECORD)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    klrp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    klrp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> rtl/klrp_checker.sv
module klrp_checker
    import klrp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tuser,
    input logic               m_tlast
);

    // The output register must come out of reset empty.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled output transaction changed");

    // An end-of-message mark is always the final result of its input byte.
    a_mark_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && m_tdata[7:0] == 8'd0)
        else $error("end mark not last or carries a byte");

    // Zero and newline split or end messages and never go out as text.
    a_text_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[7:0] != CH_NUL && m_tdata[7:0] != CH_LF)
        else $error("message byte is zero or newline");

endmodule

bind kernel_log_record_parser klrp_checker u_klrp_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import klrp_pkg::*;

    // A small record limit lets the long-record path be reached with short records.
    localparam int REC_LIMIT  = 64;
    localparam int STIM_ITEMS = 480;
    localparam int MAX_OUT    = 5;

    localparam int TXT_LO = 0;
    localparam int PRI_LO = 8;
    localparam int FAC_LO = 11;
    localparam int SEQ_LO = 19;
    localparam int TS_LO  = SEQ_LO + NUM_W;

    localparam logic [7:0] DIGIT_0 = 8'h30;
    localparam logic [7:0] DIGIT_9 = 8'h39;
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_F = 8'h46;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_F = 8'h66;

    typedef enum logic [2:0] {
        ST_PREFIX, ST_SEQ, ST_TS, ST_REST, ST_TEXT, ST_SKIP
    } parse_state_t;

    typedef enum logic {KIND_TEXT = 1'b0, KIND_END = 1'b1} out_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       rec_end;
    } raw_byte_t;

    typedef struct packed {
        out_kind_t   kind;
        logic [7:0]  text;
        logic [2:0]  pri;
        logic [7:0]  fac;
        logic [63:0] seq;
        logic [63:0] ts;
        logic        last;
    } log_result_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = 8'h00;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;
    logic               m_tlast;

    kernel_log_record_parser #(
        .MAX_RECORD(REC_LIMIT)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    raw_byte_t   raw_bytes[$];
    log_result_t predicted_out[$];
    logic [7:0]  rec[$];
    int          total_items = 0;
    int          sent_count  = 0;
    int          mismatches  = 0;

    // Parser state as seen from outside.
    parse_state_t        pstate;
    logic [PREFIX_W-1:0] pfx_acc;
    logic [63:0]         seq_acc;
    logic [63:0]         ts_acc;
    logic [7:0]          held[3];
    int                  held_n;
    logic                msg_open;
    int                  rec_bytes;
    logic                fld_started;
    logic                fld_stopped;
    logic                hdr_seen;
    int                  step_results;

    function automatic int stage();
        if (total_items == 0) return 0;
        return (sent_count * 3) / total_items;
    endfunction

    function automatic int tx_idle_pct();
        case (stage())
            0:       return 6;
            1:       return 72;
            default: return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct();
        case (stage())
            0:       return 72;
            1:       return 6;
            default: return 0;
        endcase
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return (c >= DIGIT_0 && c <= DIGIT_9) || (c >= LOWER_A && c <= LOWER_F) ||
               (c >= UPPER_A && c <= UPPER_F);
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] c);
        logic [7:0] v;
        if (c >= DIGIT_0 && c <= DIGIT_9) v = c - DIGIT_0;
        else if (c >= LOWER_A && c <= LOWER_F) v = c - LOWER_A + 8'd10;
        else v = c - UPPER_A + 8'd10;
        return v[3:0];
    endfunction

    function automatic logic [63:0] dec_push(logic [63:0] acc, logic [3:0] d);
        if (acc > ({64{1'b1}} - 64'(d)) / 64'd10) return {64{1'b1}};
        return acc * 64'd10 + 64'(d);
    endfunction

    task automatic clear_parser();
        pstate      = ST_PREFIX;
        pfx_acc     = '0;
        seq_acc     = '0;
        ts_acc      = '0;
        held_n      = 0;
        msg_open    = 1'b0;
        rec_bytes   = 0;
        fld_started = 1'b0;
        fld_stopped = 1'b0;
        hdr_seen    = 1'b0;
    endtask

    task automatic emit_result(out_kind_t kind, logic [7:0] b);
        log_result_t r;
        if (step_results >= MAX_OUT) return;
        r.kind = kind;
        r.text = (kind == KIND_END) ? 8'h00 : b;
        if (pfx_acc != '0) begin
            r.pri = pfx_acc[2:0];
            r.fac = pfx_acc[10:3];
        end else begin
            r.pri = PRI_DEFAULT;
            r.fac = FAC_DEFAULT;
        end
        r.seq  = seq_acc;
        r.ts   = ts_acc;
        r.last = 1'b0;
        predicted_out.push_back(r);
        step_results++;
    endtask

    task automatic close_message();
        if (msg_open) begin
            emit_result(KIND_END, 8'h00);
            msg_open = 1'b0;
        end
    endtask

    task automatic put_decoded(logic [7:0] c);
        if (c == CH_NUL) begin
            close_message();
            pstate = ST_SKIP;
            held_n = 0;
        end else if (c == CH_LF) begin
            close_message();
        end else begin
            emit_result(KIND_TEXT, c);
            msg_open = 1'b1;
        end
    endtask

    task automatic flush_held();
        int n;
        n = held_n;
        held_n = 0;
        for (int i = 0; i < n && i < 3; i++) put_decoded(held[i]);
    endtask

    task automatic text_in(logic [7:0] b);
        if (b == CH_LF || b == CH_NUL) begin
            flush_held();
            close_message();
            pstate = ST_SKIP;
            return;
        end
        if (held_n == 1 && b == CH_X) begin
            held[1] = b;
            held_n = 2;
            return;
        end
        if (held_n == 2 && is_hex(b)) begin
            held[2] = b;
            held_n = 3;
            return;
        end
        if (held_n == 3 && is_hex(b)) begin
            held_n = 0;
            put_decoded({hex_val(held[2]), hex_val(b)});
            return;
        end
        // A broken escape goes out literally, then this byte is taken afresh.
        if (held_n != 0) begin
            flush_held();
            if (pstate != ST_TEXT) return;
        end
        if (b == CH_BSLASH) begin
            held[0] = b;
            held_n = 1;
        end else begin
            put_decoded(b);
        end
    endtask

    task automatic header_in(logic [7:0] b);
        int v;
        logic [7:0] d;
        if (b == CH_NUL) begin
            pstate = ST_SKIP;
            return;
        end
        if (b == CH_SEMI) begin
            if (hdr_seen) pstate = ST_TEXT;
            return;
        end
        hdr_seen = 1'b1;
        if (b == CH_COMMA) begin
            // Empty fields do not advance the field number.
            if (pstate < ST_REST && fld_started) begin
                pstate = parse_state_t'(pstate + 1);
                fld_started = 1'b0;
                fld_stopped = 1'b0;
            end
            return;
        end
        if (pstate >= ST_REST) return;
        fld_started = 1'b1;
        if (b >= DIGIT_0 && b <= DIGIT_9 && !fld_stopped) begin
            d = b - DIGIT_0;
            case (pstate)
                ST_PREFIX: begin
                    v = int'(pfx_acc) * 10 + int'(d);
                    pfx_acc = (v > int'(PREFIX_MAX)) ? PREFIX_MAX : v[PREFIX_W-1:0];
                end
                ST_SEQ:  seq_acc = dec_push(seq_acc, d[3:0]);
                default: ts_acc  = dec_push(ts_acc, d[3:0]);
            endcase
        end else begin
            fld_stopped = 1'b1;
        end
    endtask

    task automatic parse_log_byte(logic [7:0] b, logic rec_end);
        log_result_t r;
        step_results = 0;
        if (rec_bytes < REC_LIMIT - 1) begin
            rec_bytes++;
            if (pstate < ST_TEXT) header_in(b);
            else if (pstate == ST_TEXT) text_in(b);
        end
        if (rec_end) begin
            if (pstate == ST_TEXT) begin
                flush_held();
                close_message();
            end
            clear_parser();
        end
        if (step_results > 0) begin
            r = predicted_out.pop_back();
            r.last = 1'b1;
            predicted_out.push_back(r);
        end
    endtask

    // Stimulus builders.
    task automatic push_raw(logic [7:0] b, logic rec_end);
        raw_byte_t item;
        item.data    = b;
        item.rec_end = rec_end;
        raw_bytes.push_back(item);
    endtask

    task automatic push_str(string s, logic end_it);
        for (int i = 0; i < s.len(); i++) push_raw(s[i], end_it && (i == s.len() - 1));
    endtask

    task automatic add_digits(int n);
        for (int i = 0; i < n; i++) rec.push_back(DIGIT_0 + 8'($urandom_range(9)));
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return DIGIT_0 + 8'(n);
        return ($urandom_range(1) ? UPPER_A : LOWER_A) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(32, 126));
        if (c == CH_BSLASH) c = 8'h5F;
        return c;
    endfunction

    task automatic add_escape();
        logic [7:0] v;
        case ($urandom_range(7))
            0:       v = CH_LF;
            1:       v = CH_NUL;
            default: v = 8'($urandom_range(1, 255));
        endcase
        rec.push_back(CH_BSLASH);
        rec.push_back(CH_X);
        rec.push_back(hex_char(v[7:4]));
        rec.push_back(hex_char(v[3:0]));
    endtask

    task automatic add_broken_escape();
        string breakers;
        int k;
        breakers = "gz!\\ ;";
        k = $urandom_range(2);
        rec.push_back(CH_BSLASH);
        if (k >= 1) rec.push_back(CH_X);
        if (k >= 2) rec.push_back(hex_char(4'($urandom_range(15))));
        rec.push_back(breakers[$urandom_range(breakers.len() - 1)]);
    endtask

    task automatic add_number_field(logic wide);
        if (wide && $urandom_range(3) == 0) add_digits($urandom_range(19, 22));
        else add_digits($urandom_range(0, wide ? 6 : 4));
        if ($urandom_range(7) == 0) rec.push_back(8'h6B);
    endtask

    task automatic gen_record(logic cut);
        int pieces;
        int len;
        rec.delete();
        if ($urandom_range(9) == 0) rec.push_back(CH_SEMI);
        add_number_field(1'b0);
        rec.push_back(CH_COMMA);
        if ($urandom_range(7) == 0) rec.push_back(CH_COMMA);
        add_number_field(1'b1);
        rec.push_back(CH_COMMA);
        add_number_field(1'b1);
        if ($urandom_range(3) == 0) begin
            rec.push_back(CH_COMMA);
            add_digits(2);
        end
        rec.push_back(CH_SEMI);
        pieces = ($urandom_range(11) == 0) ? 40 : $urandom_range(1, 8);
        for (int i = 0; i < pieces; i++) begin
            case ($urandom_range(9))
                5: add_escape();
                6: add_broken_escape();
                7: begin
                    rec.push_back(CH_LF);
                    rec.push_back(plain_char());
                    rec.push_back(plain_char());
                end
                8: rec.push_back(8'($urandom_range(128, 255)));
                9: rec.push_back(CH_BSLASH);
                default: rec.push_back(plain_char());
            endcase
        end
        if ($urandom_range(3) == 0) rec.push_back(CH_LF);
        if (cut) begin
            len = $urandom_range(1, rec.size());
            rec = rec[0:len-1];
        end
        foreach (rec[i]) push_raw(rec[i], i == rec.size() - 1);
    endtask

    task automatic gen_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) push_raw(8'($urandom_range(255)), $urandom_range(15) == 0);
    endtask

    // Driver: a transaction is held until accepted, then the next one follows.
    always @(posedge aclk) begin : drive
        raw_byte_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_log_byte(s_tdata, s_tlast);
                sent_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (raw_bytes.size() > 0 && $urandom_range(99) >= tx_idle_pct()) begin
                    item = raw_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= item.data;
                    s_tlast  <= item.rec_end;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every accepted result is checked against the oldest prediction.
    always @(posedge aclk) begin : monitor
        log_result_t want;
        log_result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct());
            if (m_tvalid && m_tready) begin
                got.kind = out_kind_t'(m_tuser);
                got.text = m_tdata[TXT_LO +: 8];
                got.pri  = m_tdata[PRI_LO +: 3];
                got.fac  = m_tdata[FAC_LO +: 8];
                got.seq  = m_tdata[SEQ_LO +: NUM_W];
                got.ts   = m_tdata[TS_LO +: NUM_W];
                got.last = m_tlast;
                if (predicted_out.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind=%0d text=%h pri=%0d fac=%0d seq=%h ts=%h last=%0d",
                                 got.kind, got.text, got.pri, got.fac, got.seq, got.ts, got.last);
                end else begin
                    want = predicted_out.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected kind=%0d text=%h pri=%0d fac=%0d seq=%h ts=%h last=%0d",
                                     want.kind, want.text, want.pri, want.fac, want.seq, want.ts,
                                     want.last);
                            $display("          actual   kind=%0d text=%h pri=%0d fac=%0d seq=%h ts=%h last=%0d",
                                     got.kind, got.text, got.pri, got.fac, got.seq, got.ts, got.last);
                        end
                    end
                end
            end
        end
    end

    initial begin
        clear_parser();
        // Escapes decoding to a byte and to a newline, then one broken after the x.
        push_str("9;\\x41\\x0A\\xz", 1'b1);
        // Leading semicolon, the top byte value, and a decoded zero ending the text.
        push_str(";5;", 1'b0);
        push_raw(8'hFF, 1'b0);
        push_str("\\x00b", 1'b1);
        // A zero byte in the header drops the record.
        push_raw(CH_NUL, 1'b1);
        while (raw_bytes.size() < STIM_ITEMS) begin
            case ($urandom_range(9))
                0:       gen_noise();
                1:       gen_record(1'b1);
                default: gen_record(1'b0);
            endcase
        end
        total_items = raw_bytes.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        while (raw_bytes.size() != 0 || s_tvalid) @(posedge aclk);
        while (predicted_out.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && predicted_out.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
rtl/klrp_pkg.sv
rtl/klrp_front.sv
rtl/klrp_queue.sv
rtl/klrp_back.sv
rtl/kernel_log_record_parser.sv
rtl/klrp_checker.sv
tb/testbench.sv
